[hdl/ssmva_pkg.sv]
package ssmva_pkg;

  localparam int unsigned RowW    = 12;
  localparam int unsigned LaneW   = 2;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned StripeW = 16;
  localparam int unsigned MantW   = 50;   // working mantissa, normal position at bit 47

  localparam logic [31:0] NanCanon = 32'h7fc0_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // normalize, round to nearest even and pack a single precision value
  // value = m * 2^(e - 127 - 47)
  function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [11:0] e,
                                          input logic [MantW-1:0] m);
    logic [5:0]         pos;
    logic signed [11:0] en;
    logic signed [11:0] rs;
    logic [11:0]        eb;
    logic [63:0]        w;
    logic [63:0]        sh;
    logic               sticky;
    logic               rnd;
    logic [24:0]        mr;
    logic [35:0]        ext;
    pos = '0;
    for (int i = 0; i < MantW; i++) begin
      if (m[i]) pos = 6'(i);
    end
    en = e + $signed({6'b0, pos}) - 12'sd47;
    if (en >= 12'sd1) begin
      rs = $signed({6'b0, pos}) - 12'sd47;
      eb = 12'(en - 12'sd1);
    end else begin
      rs = 12'sd1 - e;
      eb = '0;
    end
    w = {14'b0, m};
    if (rs < 12'sd0) begin
      sh     = w << 6'(-rs);
      sticky = 1'b0;
    end else begin
      sh     = w >> 7'(rs);
      sticky = |(w & ~({64{1'b1}} << 7'(rs)));
    end
    rnd = sh[23] & ((|sh[22:0]) | sticky | sh[24]);
    mr  = {1'b0, sh[47:24]} + {24'b0, rnd};
    ext = {1'b0, eb, 23'b0} + {11'b0, mr};
    if (m == '0) begin
      fp_pack = {sgn, 31'b0};
    end else if (ext[35:23] >= 13'd255) begin
      fp_pack = {sgn, 8'hff, 23'b0};
    end else begin
      fp_pack = {sgn, ext[30:0]};
    end
  endfunction

endpackage

[hdl/strided_sparse_matvec_accumulate.sv]
// Sparse transposed matrix-vector product over stripes of four columns. Load transfers
// (tuser = 0) write one float32 vector element into an on-chip memory of VECTOR_DEPTH words;
// an element must be loaded before any entry reads it. Entry transfers (tuser = 1) multiply
// a float32 matrix value by the vector element at row_index and add the product into the
// float32 accumulator of the given lane, with separately rounded multiply and add (round to
// nearest even, subnormals kept, NaN results made canonical). End transfers (tuser = 2) send
// out one result with the stripe number and the four lane sums and clear the sums.
// Rate: one transfer per cycle while the result output is not held by back-pressure; an
// entry that directly follows an entry of the same lane also waits for the accumulator
// write-back. The pipeline is memory read, multiply, product rounding, align and add, sum
// rounding; an end transfer passes the same steps and its result is then registered. The
// vector memory needs no clearing pass after reset.
module strided_sparse_matvec_accumulate #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // row_index[11:0], value_bits[43:12], lane[45:44]
  input  logic [1:0]   s_axis_tuser,   // action[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // stripe_number[15:0], sum_lane0..3 [47:16]..[143:112]
);
  import ssmva_pkg::*;

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // input unpacking
  logic [RowW-1:0]  in_row;
  logic [31:0]      in_value;
  logic [LaneW-1:0] in_lane;
  action_e          in_act;
  logic             in_take;
  logic             in_row_ok;
  logic [AW-1:0]    mem_addr;

  assign in_row    = s_axis_tdata[11:0];
  assign in_value  = s_axis_tdata[43:12];
  assign in_lane   = s_axis_tdata[45:44];
  assign in_act    = action_e'(s_axis_tuser);
  assign in_take   = s_axis_tvalid & s_axis_tready;
  assign in_row_ok = ({20'b0, in_row} < 32'(VECTOR_DEPTH));
  assign mem_addr  = AW'(in_row);

  // vector memory, registered read
  logic [31:0] vec_mem [VECTOR_DEPTH];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_take && in_act == ACT_LOAD && in_row_ok) begin
      vec_mem[mem_addr] <= in_value;
    end
    if (in_take && in_act == ACT_ENTRY && in_row_ok) begin
      rd_q <= vec_mem[mem_addr];
    end
  end

  // pipeline registers
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_end_q, s2_end_q, s3_end_q, s4_end_q;
  logic [LaneW-1:0] s1_lane_q, s2_lane_q, s3_lane_q, s4_lane_q;
  logic [31:0] s1_value_q;
  logic        s1_ok_q;
  logic        s2_spec_q, s4_spec_q;
  logic [31:0] s2_spec_val_q, s4_spec_val_q;
  logic        s2_sgn_q, s4_sgn_q;
  logic signed [11:0] s2_exp_q, s4_exp_q;
  logic [47:0] s2_prod_q;
  logic [MantW-1:0] s4_mant_q;
  logic [31:0] s3_prod_q;

  logic [Lanes-1:0][31:0] acc_q;
  logic [StripeW-1:0] stripe_q;
  logic         out_v_q;
  logic [143:0] out_data_q;

  // flow control
  logic out_block, adv4, hazard, adv3, front;

  assign out_block = s4_v_q & s4_end_q & out_v_q & ~m_axis_tready;
  assign adv4      = ~out_block;
  // an entry may not read an accumulator that the entry ahead is still rounding
  assign hazard    = s3_v_q & ~s3_end_q & s4_v_q & ~s4_end_q & (s3_lane_q == s4_lane_q);
  assign adv3      = adv4 & ~hazard;
  assign front     = adv3 | ~s3_v_q;
  assign s_axis_tready = front;

  // multiply stage: special operands and mantissa product
  logic [31:0] ma_op, mb_op;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, mul_sgn;
  logic        mul_spec;
  logic [31:0] mul_spec_val;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  always_comb begin
    ma_op   = s1_value_q;
    mb_op   = s1_ok_q ? rd_q : 32'b0;
    a_nan   = (ma_op[30:23] == 8'hff) & (ma_op[22:0] != '0);
    b_nan   = (mb_op[30:23] == 8'hff) & (mb_op[22:0] != '0);
    a_inf   = (ma_op[30:23] == 8'hff) & (ma_op[22:0] == '0);
    b_inf   = (mb_op[30:23] == 8'hff) & (mb_op[22:0] == '0);
    a_zero  = (ma_op[30:0] == '0);
    b_zero  = (mb_op[30:0] == '0);
    mul_sgn = ma_op[31] ^ mb_op[31];
    ma      = {ma_op[30:23] != '0, ma_op[22:0]};
    mb      = {mb_op[30:23] != '0, mb_op[22:0]};
    ea      = (ma_op[30:23] == '0) ? 8'd1 : ma_op[30:23];
    eb      = (mb_op[30:23] == '0) ? 8'd1 : mb_op[30:23];
    mul_spec     = 1'b1;
    mul_spec_val = {mul_sgn, 31'b0};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      mul_spec_val = NanCanon;
    end else if (a_inf || b_inf) begin
      mul_spec_val = {mul_sgn, 8'hff, 23'b0};
    end else if (!(a_zero || b_zero)) begin
      mul_spec = 1'b0;
    end
  end

  // add stage: accumulator operand, alignment and add
  logic [31:0] add_a, add_b, big, sml;
  logic        aa_nan, ab_nan, aa_inf, ab_inf;
  logic        add_spec;
  logic [31:0] add_spec_val;
  logic [7:0]  e_big, e_sml, e_diff;
  logic [MantW-1:0] m_big, m_sml, m_al, m_sum;
  logic        add_sgn;

  always_comb begin
    // an end item ahead clears the sums as this entry reads them
    add_a  = (s4_v_q && s4_end_q) ? 32'b0 : acc_q[s3_lane_q];
    add_b  = s3_prod_q;
    aa_nan = (add_a[30:23] == 8'hff) & (add_a[22:0] != '0);
    ab_nan = (add_b[30:23] == 8'hff) & (add_b[22:0] != '0);
    aa_inf = (add_a[30:23] == 8'hff) & (add_a[22:0] == '0);
    ab_inf = (add_b[30:23] == 8'hff) & (add_b[22:0] == '0);
    add_spec     = 1'b1;
    add_spec_val = NanCanon;
    if (aa_nan || ab_nan || (aa_inf && ab_inf && (add_a[31] != add_b[31]))) begin
      add_spec_val = NanCanon;
    end else if (aa_inf) begin
      add_spec_val = add_a;
    end else if (ab_inf) begin
      add_spec_val = add_b;
    end else begin
      add_spec = 1'b0;
    end
    if (add_a[30:0] >= add_b[30:0]) begin
      big = add_a;
      sml = add_b;
    end else begin
      big = add_b;
      sml = add_a;
    end
    e_big  = (big[30:23] == '0) ? 8'd1 : big[30:23];
    e_sml  = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    e_diff = e_big - e_sml;
    m_big  = {2'b0, big[30:23] != '0, big[22:0], 24'b0};
    m_sml  = {2'b0, sml[30:23] != '0, sml[22:0], 24'b0};
    m_al   = m_sml >> e_diff;
    m_al[0] = m_al[0] | (|(m_sml & ~({MantW{1'b1}} << e_diff)));
    m_sum  = (add_a[31] == add_b[31]) ? (m_big + m_al) : (m_big - m_al);
    // exact zero is positive unless both operands are negative
    add_sgn = (m_sum == '0) ? (add_a[31] & add_b[31]) : big[31];
  end

  logic [31:0] prod_bits, sum_bits;
  assign prod_bits = s2_spec_q ? s2_spec_val_q : fp_pack(s2_sgn_q, s2_exp_q, {2'b0, s2_prod_q});
  assign sum_bits  = s4_spec_q ? s4_spec_val_q : fp_pack(s4_sgn_q, s4_exp_q, s4_mant_q);

  // control of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      stripe_q <= '0;
      acc_q    <= '0;
    end else begin
      if (front) begin
        s1_v_q <= in_take & ((in_act == ACT_ENTRY) | (in_act == ACT_END));
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
      if (adv4) begin
        s4_v_q <= s3_v_q & adv3;
      end
      if (s4_v_q && adv4 && s4_end_q) begin
        out_v_q  <= 1'b1;
        stripe_q <= stripe_q + 1'b1;
        acc_q    <= '0;
      end else begin
        if (m_axis_tready) out_v_q <= 1'b0;
        if (s4_v_q && adv4) acc_q[s4_lane_q] <= sum_bits;
      end
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk_i) begin
    if (front) begin
      s1_end_q      <= (in_act == ACT_END);
      s1_lane_q     <= in_lane;
      s1_value_q    <= in_value;
      s1_ok_q       <= in_row_ok;
      s2_end_q      <= s1_end_q;
      s2_lane_q     <= s1_lane_q;
      s2_spec_q     <= mul_spec;
      s2_spec_val_q <= mul_spec_val;
      s2_sgn_q      <= mul_sgn;
      s2_exp_q      <= $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
      s2_prod_q     <= ma * mb;
      s3_end_q      <= s2_end_q;
      s3_lane_q     <= s2_lane_q;
      s3_prod_q     <= prod_bits;
    end
    if (adv3) begin
      s4_end_q      <= s3_end_q;
      s4_lane_q     <= s3_lane_q;
      s4_spec_q     <= add_spec;
      s4_spec_val_q <= add_spec_val;
      s4_sgn_q      <= add_sgn;
      s4_exp_q      <= $signed({4'b0, e_big});
      s4_mant_q     <= m_sum;
    end
    if (s4_v_q && adv4 && s4_end_q) begin
      out_data_q <= {acc_q[3], acc_q[2], acc_q[1], acc_q[0], stripe_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[hdl/ssmva_chk.sv]
module ssmva_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);
  import ssmva_pkg::*;

  logic [15:0] pend_q;
  logic [15:0] exp_stripe_q;
  logic        end_in, res_out;

  assign end_in  = s_axis_tvalid & s_axis_tready & (action_e'(s_axis_tuser) == ACT_END);
  assign res_out = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      exp_stripe_q <= '0;
    end else begin
      pend_q <= pend_q + {15'b0, end_in} - {15'b0, res_out};
      if (res_out) exp_stripe_q <= exp_stripe_q + 1'b1;
    end
  end

  // a held result keeps its valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its data
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every result comes from an end transfer not yet answered
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 16'd0)
    else $error("result without end transfer");

  // stripe numbers count up from zero
  a_stripe_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out |-> m_axis_tdata[15:0] == exp_stripe_q)
    else $error("stripe number out of sequence");

endmodule

bind strided_sparse_matvec_accumulate ssmva_chk u_ssmva_chk (.*);
